// File: hdl/scib_pkg.sv
// Shared types, codes and CRC-32C helpers for the shard chunk index builder.
// Depends on nothing; used by shard_chunk_index_builder_top.
`default_nettype none

package scib_pkg;

  // Default number of table slots
  localparam int CHUNKS_DEF = 16;

  // Field widths
  localparam int OP_W   = 2;
  localparam int IDX_FW = 8;
  localparam int SIZE_W = 32;
  localparam int ST_W   = 3;
  localparam int POS_W  = 64;
  localparam int CRC_W  = 32;
  localparam int REM_W  = 7;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 296;

  // Reflected CRC-32C polynomial
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SKIP  = 2'd1,
    OP_FINAL = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  // Status codes
  typedef enum logic [ST_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_RANGE = 3'd1,
    STAT_DUP   = 3'd2,
    STAT_UNDER = 3'd3,
    STAT_FINAL = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_WALK_RD,
    S_WALK_OFS,
    S_WALK_EXT,
    S_CLOSE
  } state_t;

  // Outcome of the table lookup for one request
  typedef struct packed {
    status_t           status;
    logic              start_final;
    logic              we;
    logic              dec_rem;
    logic [POS_W-1:0]  assigned;
  } look_dec_t;

  // Byte-wise CRC table, built at elaboration
  typedef logic [255:0][CRC_W-1:0] crc_tbl_t;

  function automatic crc_tbl_t crc_tbl_gen();
    crc_tbl_t         t;
    logic [CRC_W-1:0] c;
    for (int n = 0; n < 256; n++) begin
      c = CRC_W'(n);
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[n] = c;
    end
    return t;
  endfunction

  localparam crc_tbl_t CRC_TBL = crc_tbl_gen();

  // Fold one 64-bit word into the CRC, low byte first
  function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] crc_in,
                                                input logic [63:0] v);
    logic [CRC_W-1:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 8) ^ CRC_TBL[c[7:0] ^ v[8*i +: 8]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/shard_chunk_index_builder_top.sv
// Shard chunk index builder: offset/extent table in one synchronous RAM,
// write/skip bookkeeping, finalize walk with CRC-32C. Depends on scib_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: op, chunk_index, chunk_size
//  out_    | out | out_tvalid/tready  | tdata: status..index_position, tuser kind, tlast
//
// A write, skip or rejected request is accepted in S_IDLE, then its table read and
//   decision come in S_LOOK, which waits for the RAM's registered read.
// A finalizing request: accept, decision, then read, offset CRC, extent CRC and emit
//   per entry through the single RAM read port, then the closing status.
// Reset clears control state and the per-entry valid bits; no clearing pass.
// Output stalls hold the sequencer in place; the result register waits for out_tready.
`default_nettype none

module shard_chunk_index_builder_top #(
  parameter int CHUNKS = scib_pkg::CHUNKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input items
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [scib_pkg::IN_DATA_W-1:0]  in_tdata,   // op[1:0], chunk_index[9:2],
                                                           // chunk_size[41:10], zero pad
  // result items
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [scib_pkg::OUT_DATA_W-1:0]      out_tdata,  // status[2:0], assigned_offset,
                                                           // entry_offset, entry_extent,
                                                           // index_crc, index_position, pad
  output logic                                 out_tuser,  // kind
  output logic                                 out_tlast   // last
);

  localparam int IDX_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int POS_W  = scib_pkg::POS_W;
  localparam int SIZE_W = scib_pkg::SIZE_W;
  localparam int CRC_W  = scib_pkg::CRC_W;
  localparam int REM_W  = scib_pkg::REM_W;
  localparam int MEM_W  = POS_W + SIZE_W;
  localparam int PAD_W  = scib_pkg::OUT_DATA_W - (scib_pkg::ST_W + 4*POS_W + CRC_W);

  // Control state
  scib_pkg::state_t      state_r, state_nxt;
  logic [REM_W-1:0]      rem_r;
  logic [POS_W-1:0]      end_r;
  logic                  fin_r;
  logic [CRC_W-1:0]      crc_r;
  logic [IDX_W-1:0]      walk_r;
  logic [CHUNKS-1:0]     vld_r;

  // Latched request
  scib_pkg::op_t         op_r;
  logic [scib_pkg::IDX_FW-1:0] idx_r;
  logic [SIZE_W-1:0]     size_r;
  logic [POS_W-1:0]      asg_r;

  // Table RAM: {offset, size}
  logic [MEM_W-1:0]      tbl_mem [CHUNKS];
  logic [MEM_W-1:0]      rd_q;
  logic                  vld_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;

  // Output register
  logic                  out_vld_r;
  logic [scib_pkg::ST_W-1:0] o_status_r;
  logic [POS_W-1:0]      o_asg_r, o_eoff_r, o_eext_r, o_pos_r;
  logic [CRC_W-1:0]      o_crc_r;
  logic                  o_kind_r, o_last_r;

  // Combinational control
  scib_pkg::look_dec_t   dec;
  logic                  out_free;
  logic                  in_acc;
  logic                  out_ld;
  logic [scib_pkg::ST_W-1:0] ld_status;
  logic [POS_W-1:0]      ld_asg, ld_eoff, ld_eext, ld_pos;
  logic [CRC_W-1:0]      ld_crc;
  logic                  ld_kind, ld_last;
  logic [POS_W-1:0]      rd_off, rd_ext;
  logic                  walk_done;

  assign out_free  = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign rd_off    = vld_q ? rd_q[MEM_W-1 -: POS_W] : '1;
  assign rd_ext    = vld_q ? {{(POS_W-SIZE_W){1'b0}}, rd_q[SIZE_W-1:0]} : '1;
  assign walk_done = (walk_r == IDX_W'(CHUNKS - 1));

  // Request decision from the looked-up entry
  always_comb begin : look_decide
    dec = '{status: scib_pkg::STAT_OK, start_final: 1'b0, we: 1'b0, dec_rem: 1'b0,
            assigned: '0};
    if (op_r == scib_pkg::OP_FINAL) begin
      if (fin_r) begin
        dec.status = scib_pkg::STAT_FINAL;
      end else begin
        dec.start_final = 1'b1;
      end
    end else if (op_r == scib_pkg::OP_RSVD || idx_r >= scib_pkg::IDX_FW'(CHUNKS)) begin
      dec.status = scib_pkg::STAT_RANGE;
    end else if (op_r == scib_pkg::OP_WRITE && fin_r) begin
      dec.status = scib_pkg::STAT_FINAL;
    end else if (op_r == scib_pkg::OP_WRITE && rd_off != '1) begin
      dec.status = scib_pkg::STAT_DUP;
    end else begin
      // write accepted or skip: count one completion unless none remain
      dec.we       = (op_r == scib_pkg::OP_WRITE);
      dec.assigned = dec.we ? end_r : '0;
      if (rem_r == '0) begin
        dec.status = scib_pkg::STAT_UNDER;
      end else begin
        dec.dec_rem = 1'b1;
        if (fin_r) begin
          dec.status = scib_pkg::STAT_FINAL;
        end else if (rem_r == REM_W'(1)) begin
          dec.start_final = 1'b1;
        end
      end
    end
  end

  // Next state
  always_comb begin : next_state
    state_nxt = state_r;
    case (state_r)
      scib_pkg::S_IDLE: begin
        if (in_acc) state_nxt = scib_pkg::S_LOOK;
      end
      scib_pkg::S_LOOK: begin
        if (out_free) state_nxt = dec.start_final ? scib_pkg::S_WALK_RD : scib_pkg::S_IDLE;
      end
      scib_pkg::S_WALK_RD:  state_nxt = scib_pkg::S_WALK_OFS;
      scib_pkg::S_WALK_OFS: state_nxt = scib_pkg::S_WALK_EXT;
      scib_pkg::S_WALK_EXT: begin
        if (out_free) state_nxt = walk_done ? scib_pkg::S_CLOSE : scib_pkg::S_WALK_RD;
      end
      scib_pkg::S_CLOSE: begin
        if (out_free) state_nxt = scib_pkg::S_IDLE;
      end
      default: state_nxt = scib_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM control and result loading
  always_comb begin : seq_outputs
    in_tready = 1'b0;
    rd_addr   = idx_r[IDX_W-1:0];
    mem_we    = 1'b0;
    out_ld    = 1'b0;
    ld_status = scib_pkg::STAT_OK;
    ld_asg    = '0;
    ld_eoff   = '0;
    ld_eext   = '0;
    ld_crc    = '0;
    ld_pos    = '0;
    ld_kind   = 1'b0;
    ld_last   = 1'b0;
    case (state_r)
      scib_pkg::S_IDLE: begin
        in_tready = 1'b1;
        rd_addr   = in_tdata[scib_pkg::OP_W +: IDX_W];
      end
      scib_pkg::S_LOOK: begin
        mem_we    = out_free && dec.we;
        out_ld    = out_free && !dec.start_final;
        ld_status = dec.status;
        ld_asg    = dec.assigned;
        ld_last   = 1'b1;
      end
      scib_pkg::S_WALK_RD, scib_pkg::S_WALK_OFS: begin
        rd_addr = walk_r;
      end
      scib_pkg::S_WALK_EXT: begin
        rd_addr = walk_r;
        out_ld  = out_free;
        ld_kind = 1'b1;
        ld_eoff = rd_off;
        ld_eext = rd_ext;
      end
      scib_pkg::S_CLOSE: begin
        out_ld  = out_free;
        ld_asg  = asg_r;
        ld_crc  = ~crc_r;
        ld_pos  = end_r;
        ld_last = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= scib_pkg::S_IDLE;
      rem_r     <= REM_W'(CHUNKS);
      end_r     <= '0;
      fin_r     <= 1'b0;
      crc_r     <= '1;
      walk_r    <= '0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      // lookup commit
      if (state_r == scib_pkg::S_LOOK && out_free) begin
        if (dec.dec_rem) rem_r <= rem_r - REM_W'(1);
        if (dec.we) begin
          end_r                     <= end_r + {{(POS_W-SIZE_W){1'b0}}, size_r};
          vld_r[idx_r[IDX_W-1:0]]   <= 1'b1;
        end
        if (dec.start_final) begin
          fin_r  <= 1'b1;
          crc_r  <= '1;
          walk_r <= '0;
        end
      end
      // CRC over the entries, offset then extent
      if (state_r == scib_pkg::S_WALK_OFS) crc_r <= scib_pkg::crc_word(crc_r, rd_off);
      if (state_r == scib_pkg::S_WALK_EXT && out_free) begin
        crc_r <= scib_pkg::crc_word(crc_r, rd_ext);
        if (!walk_done) walk_r <= walk_r + IDX_W'(1);
      end
    end
  end

  // Request latch and saved offset for the closing status
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= scib_pkg::op_t'(in_tdata[scib_pkg::OP_W-1:0]);
      idx_r  <= in_tdata[scib_pkg::OP_W +: scib_pkg::IDX_FW];
      size_r <= in_tdata[scib_pkg::OP_W + scib_pkg::IDX_FW +: SIZE_W];
    end
    if (state_r == scib_pkg::S_LOOK && out_free && dec.start_final) asg_r <= dec.assigned;
  end

  // Table RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem[idx_r[IDX_W-1:0]] <= {end_r, size_r};
    rd_q  <= tbl_mem[rd_addr];
    vld_q <= vld_r[rd_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_ld) begin
      o_status_r <= ld_status;
      o_asg_r    <= ld_asg;
      o_eoff_r   <= ld_eoff;
      o_eext_r   <= ld_eext;
      o_crc_r    <= ld_crc;
      o_pos_r    <= ld_pos;
      o_kind_r   <= ld_kind;
      o_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD_W{1'b0}}, o_pos_r, o_crc_r, o_eext_r, o_eoff_r, o_asg_r,
                       o_status_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

  // Checks
  a_entry_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && o_kind_r |-> !o_last_r)
    else $error("entry result marked last");

  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(fin_r))
    else $error("finalized flag cleared");

  a_no_write_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !fin_r)
    else $error("table written after finalize");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= REM_W'(CHUNKS))
    else $error("completion counter above table size");

  a_walk_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scib_pkg::S_WALK_RD || state_r == scib_pkg::S_WALK_OFS ||
     state_r == scib_pkg::S_WALK_EXT || state_r == scib_pkg::S_CLOSE) |-> fin_r)
    else $error("table walk without finalized flag");

endmodule

`default_nettype wire
